>>> sv/gamma_ramp_generator_unit_defines.svh
// Assertion macros for the gamma ramp generator.
// Taken in by `include in the files that check their own logic.
`ifndef GAMMA_RAMP_GENERATOR_UNIT_DEFINES_SVH
`define GAMMA_RAMP_GENERATOR_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
// prop is a full property, clocked on clk and disabled during reset
`define GRG_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("grg assertion failed");
// non-overlapping implication, cons checked in the cycle after ante
`define GRG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("grg assertion failed");
`else
`define GRG_ASSERT(lbl, clk, rst_n, prop)
`define GRG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

>>> sv/grg_pkg.sv
// Package for the gamma ramp generator: widths, constants, item tags and
// the log2 and exp2 root tables built at elaboration. No dependencies.
package grg_pkg;

    localparam int TABLE_ENTRIES = 256;   // power of two
    localparam int IDX_W         = 8;
    localparam int SHIFT_W       = 2;
    localparam int GAMMA_W       = 15;
    localparam int CONTRAST_W    = 15;
    localparam int BRIGHT_W      = 16;
    localparam int VALUE_W       = 16;
    localparam int CFG_ADDR_W    = 2;
    localparam int CFG_DATA_W    = 16;

    localparam logic [CFG_ADDR_W-1:0] CFG_OVERBRIGHT = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_GAMMA      = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_CONTRAST   = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_BRIGHTNESS = 2'd3;

    localparam logic [GAMMA_W-1:0] GAMMA_MIN = 15'd410;
    localparam logic [GAMMA_W-1:0] GAMMA_MAX = 15'd20480;
    localparam logic [GAMMA_W-1:0] GAMMA_ONE = 15'd4096;

    localparam int FRAC_BITS = 28;
    localparam int LOG_W     = 32;
    localparam int DIFF_W    = 31;
    localparam int DIV_NUM_W = 44;
    localparam int DIV_BITS  = 4;
    localparam int MANT_W    = 31;        // Q30 mantissa, below 2.0

    localparam int LIN_SHIFT = $clog2(TABLE_ENTRIES) + 16;
    localparam logic [23:0] LIN_BRIGHT = 24'(65535 * TABLE_ENTRIES);

    typedef logic [LOG_W-1:0]  t_log_tab  [0:255];
    typedef logic [MANT_W-1:0] t_root_tab [1:FRAC_BITS];

    typedef struct packed {
        logic [IDX_W-1:0] idx;
        logic             neg;
    } t_div_tag;

    typedef struct packed {
        logic [IDX_W-1:0] idx;
        logic             sat;
        logic             yzero;
        logic signed [7:0] sh;
    } t_exp_tag;

    function automatic logic [63:0] isqrt64(input logic [63:0] v);
        logic [63:0] r;
        logic [63:0] b;
        logic [63:0] x;
        r = '0;
        b = 64'd1 << 62;
        x = v;
        while (b > x) b = b >> 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // Q28 log2 by leading-one position and repeated squaring
    function automatic logic [LOG_W-1:0] log2_q28(input logic [63:0] m);
        logic [63:0] z;
        logic [63:0] frac;
        int k;
        frac = '0;
        k = 0;
        if (m == 0) return '0;
        while (k < 30 && (m >> (k + 1)) != 0) k++;
        z = (m << (30 - k)) & ((64'd1 << 31) - 64'd1);
        for (int j = 0; j < FRAC_BITS; j++) begin
            z = (z * z) >> 30;
            frac = frac << 1;
            if (z >= (64'd1 << 31)) begin
                z = z >> 1;
                frac = frac | 64'd1;
            end
        end
        return LOG_W'((64'(k) << FRAC_BITS) | frac);
    endfunction

    function automatic t_log_tab build_log_tab();
        t_log_tab t;
        for (int i = 0; i < 256; i++) t[i] = log2_q28(64'(i));
        return t;
    endfunction

    // 2^(2^-j) in Q30
    function automatic t_root_tab build_root_tab();
        t_root_tab t;
        logic [63:0] prev;
        prev = isqrt64(64'd2 << 60);
        t[1] = MANT_W'(prev);
        for (int j = 2; j <= FRAC_BITS; j++) begin
            prev = isqrt64(prev << 30);
            t[j] = MANT_W'(prev);
        end
        return t;
    endfunction

    localparam t_log_tab  LOG_TAB  = build_log_tab();
    localparam t_root_tab ROOT_TAB = build_root_tab();
    localparam logic [LOG_W-1:0] LOG_DEN = log2_q28(64'(TABLE_ENTRIES - 1));

endpackage

>>> sv/grg_divider.sv
// Pipelined restoring divider, DIV_BITS quotient bits per stage.
// Uses grg_pkg; the tag rides alongside each item.
module grg_divider #(
    parameter int TAG_W = 9
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_ce,
    input  logic                          i_valid,
    input  logic [grg_pkg::DIV_NUM_W-1:0] i_num,
    input  logic [grg_pkg::GAMMA_W-1:0]   i_den,
    input  logic [TAG_W-1:0]              i_tag,
    output logic                          o_valid,
    output logic [grg_pkg::DIV_NUM_W-1:0] o_quo,
    output logic [TAG_W-1:0]              o_tag
);
    import grg_pkg::*;

    localparam int N_ST = DIV_NUM_W / DIV_BITS;

    logic [GAMMA_W-1:0]   r_rem [N_ST];
    logic [DIV_NUM_W-1:0] r_nq  [N_ST];
    logic [TAG_W-1:0]     r_tag [N_ST];
    logic [N_ST-1:0]      r_vld;

    for (genvar s = 0; s < N_ST; s++) begin : g_st
        logic [GAMMA_W-1:0]   rem_in;
        logic [DIV_NUM_W-1:0] nq_in;
        logic [TAG_W-1:0]     tag_in;
        logic                 vld_in;
        logic [GAMMA_W-1:0]   n_rem;
        logic [DIV_NUM_W-1:0] n_nq;

        if (s == 0) begin : g_first
            assign rem_in = '0;
            assign nq_in  = i_num;
            assign tag_in = i_tag;
            assign vld_in = i_valid;
        end else begin : g_next
            assign rem_in = r_rem[s-1];
            assign nq_in  = r_nq[s-1];
            assign tag_in = r_tag[s-1];
            assign vld_in = r_vld[s-1];
        end

        // nq holds the unused numerator bits on top, quotient bits enter below
        always_comb begin
            logic [GAMMA_W:0] t;
            n_rem = rem_in;
            n_nq  = nq_in;
            for (int k = 0; k < DIV_BITS; k++) begin
                t    = {n_rem, n_nq[DIV_NUM_W-1]};
                n_nq = {n_nq[DIV_NUM_W-2:0], 1'b0};
                if (t >= {1'b0, i_den}) begin
                    t       = t - {1'b0, i_den};
                    n_nq[0] = 1'b1;
                end
                n_rem = t[GAMMA_W-1:0];
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else if (i_ce) begin
                r_vld[s] <= vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_ce) begin
                r_rem[s] <= n_rem;
                r_nq[s]  <= n_nq;
                r_tag[s] <= tag_in;
            end
        end
    end

    assign o_valid = r_vld[N_ST-1];
    assign o_quo   = r_nq[N_ST-1];
    assign o_tag   = r_tag[N_ST-1];

endmodule

>>> sv/grg_exp2.sv
// Pipelined 2^frac in Q30: one conditional root multiply per stage.
// Uses grg_pkg for the root table; the tag rides alongside each item.
module grg_exp2 #(
    parameter int TAG_W = 18
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_ce,
    input  logic                          i_valid,
    input  logic [grg_pkg::FRAC_BITS-1:0] i_frac,
    input  logic [TAG_W-1:0]              i_tag,
    output logic                          o_valid,
    output logic [grg_pkg::MANT_W-1:0]    o_mant,
    output logic [TAG_W-1:0]              o_tag
);
    import grg_pkg::*;

    logic [MANT_W-1:0]    r_mant [FRAC_BITS];
    logic [FRAC_BITS-1:0] r_frac [FRAC_BITS];
    logic [TAG_W-1:0]     r_tag  [FRAC_BITS];
    logic [FRAC_BITS-1:0] r_vld;

    for (genvar s = 0; s < FRAC_BITS; s++) begin : g_st
        logic [MANT_W-1:0]    mant_in;
        logic [FRAC_BITS-1:0] frac_in;
        logic [TAG_W-1:0]     tag_in;
        logic                 vld_in;
        logic [2*MANT_W-1:0]  prod;
        logic [MANT_W-1:0]    n_mant;

        if (s == 0) begin : g_first
            assign mant_in = MANT_W'(1) << 30;
            assign frac_in = i_frac;
            assign tag_in  = i_tag;
            assign vld_in  = i_valid;
        end else begin : g_next
            assign mant_in = r_mant[s-1];
            assign frac_in = r_frac[s-1];
            assign tag_in  = r_tag[s-1];
            assign vld_in  = r_vld[s-1];
        end

        assign prod   = mant_in * ROOT_TAB[s+1];
        assign n_mant = frac_in[FRAC_BITS-1-s] ? prod[30 +: MANT_W] : mant_in;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else if (i_ce) begin
                r_vld[s] <= vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_ce) begin
                r_mant[s] <= n_mant;
                r_frac[s] <= frac_in;
                r_tag[s]  <= tag_in;
            end
        end
    end

    assign o_valid = r_vld[FRAC_BITS-1];
    assign o_mant  = r_mant[FRAC_BITS-1];
    assign o_tag   = r_tag[FRAC_BITS-1];

endmodule

>>> sv/gamma_ramp_generator_unit.sv
// Gamma ramp generator top level: config registers, log2 front end, tail
// arithmetic and output register. Uses grg_pkg, grg_divider, grg_exp2.
//
// Usage: one 8-bit level index goes in on i_valid/o_stall and one 16-bit
// ramp entry comes out on o_valid/i_stall, in the order of the items.
// Items are taken one per clock while o_stall is low; each item passes
// through the input and log2 stages (2), divider (11, four quotient
// bits a stage), exponent split (1), exp2 root multiplies (28, one per
// stage), shift, product, sum and output stages (4).
// The whole pipeline moves as one: while the output register holds an
// item and i_stall is high, every stage holds and o_stall is raised, so
// nothing is lost or repeated. Bubbles travel as cleared valid bits.
// Config registers are written through i_cfg_wr_en/i_cfg_addr/
// i_cfg_wr_data and are read live by stages throughout the pipeline, so write them only
// while the pipeline is empty.
// Synchronous active-low reset clears all valid bits and sets the
// registers to shift 0, gamma 1.0, contrast 1.0, brightness 0.
`include "gamma_ramp_generator_unit_defines.svh"

module gamma_ramp_generator_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_wr_en,
    input  logic [grg_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [grg_pkg::CFG_DATA_W-1:0] i_cfg_wr_data,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [grg_pkg::IDX_W-1:0]      i_level_index,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [grg_pkg::VALUE_W-1:0]    o_ramp_value
);
    import grg_pkg::*;

    // config
    logic [SHIFT_W-1:0]    r_ob_shift;
    logic [GAMMA_W-1:0]    r_gamma;
    logic [CONTRAST_W-1:0] r_contrast;
    logic [BRIGHT_W-1:0]   r_bright;
    logic [GAMMA_W-1:0]    w_gamma;
    logic                  w_lin;
    logic                  w_active_c;
    logic                  ce;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ob_shift <= '0;
            r_gamma    <= GAMMA_ONE;
            r_contrast <= CONTRAST_W'(4096);
            r_bright   <= '0;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_addr)
                CFG_OVERBRIGHT: r_ob_shift <= i_cfg_wr_data[SHIFT_W-1:0];
                CFG_GAMMA:      r_gamma    <= i_cfg_wr_data[GAMMA_W-1:0];
                CFG_CONTRAST:   r_contrast <= i_cfg_wr_data[CONTRAST_W-1:0];
                CFG_BRIGHTNESS: r_bright   <= i_cfg_wr_data[BRIGHT_W-1:0];
                default: ;
            endcase
        end
    end

    assign w_gamma    = (r_gamma < GAMMA_MIN) ? GAMMA_MIN :
                        (r_gamma > GAMMA_MAX) ? GAMMA_MAX : r_gamma;
    assign w_lin      = (w_gamma == GAMMA_ONE);
    assign w_active_c = (r_contrast != '0);

    logic r_out_valid;
    assign ce      = !(r_out_valid && i_stall);
    assign o_stall = r_out_valid && i_stall;
    assign o_valid = r_out_valid;

    // stage A: input register
    logic             r_a_valid;
    logic [IDX_W-1:0] r_a_idx;

    // stage B: |log2(index<<shift) - log2(entries-1)|
    logic              r_b_valid;
    logic [DIFF_W-1:0] r_b_diff;
    t_div_tag          r_b_tag;
    logic [LOG_W-1:0]  w_lx;
    logic              w_neg;
    logic [LOG_W-1:0]  w_diff;

    assign w_lx   = LOG_TAB[r_a_idx] + (LOG_W'(r_ob_shift) << FRAC_BITS);
    assign w_neg  = (w_lx < LOG_DEN);
    assign w_diff = w_neg ? (LOG_DEN - w_lx) : (w_lx - LOG_DEN);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else if (ce) begin
            r_a_valid <= i_valid;
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_a_idx     <= i_level_index;
            r_b_diff    <= w_diff[DIFF_W-1:0];
            r_b_tag.idx <= r_a_idx;
            r_b_tag.neg <= w_neg;
        end
    end

    // exponent = diff*4096/gamma
    logic                 w_div_valid;
    logic [DIV_NUM_W-1:0] w_div_quo;
    logic [DIV_NUM_W-1:0] w_div_num;
    t_div_tag             w_div_tag;

    assign w_div_num = {1'b0, r_b_diff, 12'b0};

    grg_divider #(
        .TAG_W ($bits(t_div_tag))
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (ce),
        .i_valid (r_b_valid),
        .i_num   (w_div_num),
        .i_den   (w_gamma),
        .i_tag   (r_b_tag),
        .o_valid (w_div_valid),
        .o_quo   (w_div_quo),
        .o_tag   (w_div_tag)
    );

    // stage P: split into shift and fraction; negative side rounds up
    logic                 r_p_valid;
    logic [FRAC_BITS-1:0] r_p_frac;
    t_exp_tag             r_p_tag;
    logic [15:0]          w_hi;
    logic [FRAC_BITS-1:0] w_low;
    logic [16:0]          w_q;
    logic                 w_active;
    t_exp_tag             n_p_tag;
    logic [FRAC_BITS-1:0] n_p_frac;

    assign w_hi     = w_div_quo[DIV_NUM_W-1:FRAC_BITS];
    assign w_low    = w_div_quo[FRAC_BITS-1:0];
    assign w_q      = {1'b0, w_hi} + 17'(w_low != '0);
    assign w_active = (w_div_tag.idx != '0) && w_active_c;

    always_comb begin
        n_p_tag.idx = w_div_tag.idx;
        n_p_tag.sat = w_active && !w_div_tag.neg && (w_hi >= 16'd16);
        if (w_div_tag.neg) begin
            n_p_frac      = -w_low;
            n_p_tag.yzero = !w_active || (w_q >= 17'd66);
            n_p_tag.sh    = 8'sd2 - $signed({1'b0, w_q[6:0]});
        end else begin
            n_p_frac      = w_low;
            n_p_tag.yzero = !w_active;
            n_p_tag.sh    = 8'sd2 + $signed({4'b0, w_hi[3:0]});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
        end else if (ce) begin
            r_p_valid <= w_div_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_p_frac <= n_p_frac;
            r_p_tag  <= n_p_tag;
        end
    end

    logic              w_exp_valid;
    logic [MANT_W-1:0] w_exp_r;
    t_exp_tag          w_exp_tag;

    grg_exp2 #(
        .TAG_W ($bits(t_exp_tag))
    ) u_exp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (ce),
        .i_valid (r_p_valid),
        .i_frac  (r_p_frac),
        .i_tag   (r_p_tag),
        .o_valid (w_exp_valid),
        .o_mant  (w_exp_r),
        .o_tag   (w_exp_tag)
    );

    // T1: y = mantissa scaled to Q32
    logic             r_t1_valid;
    logic [44:0]      r_t1_y;
    logic             r_t1_sat;
    logic [IDX_W-1:0] r_t1_idx;
    logic [47:0]      w_y48;
    logic [7:0]       w_rsh;

    assign w_rsh = 8'(-w_exp_tag.sh);

    always_comb begin
        if (w_exp_tag.yzero) begin
            w_y48 = '0;
        end else if (!w_exp_tag.sh[7]) begin
            w_y48 = {17'b0, w_exp_r} << w_exp_tag.sh[4:0];
        end else begin
            w_y48 = {17'b0, w_exp_r} >> w_rsh;
        end
    end

    // T2: partial products of y*contrast, and the linear product
    logic             r_t2_valid;
    logic [37:0]      r_t2_pl;
    logic [36:0]      r_t2_ph;
    logic [25:0]      r_t2_plin;
    logic             r_t2_sat;
    logic [IDX_W-1:0] r_t2_idx;
    logic [10:0]      w_sidx;

    assign w_sidx = {3'b0, r_t1_idx} << r_ob_shift;

    // T3: sum and linear result
    logic             r_t3_valid;
    logic [44:0]      r_t3_d;
    logic             r_t3_sat;
    logic [15:0]      r_t3_lin;
    logic [IDX_W-1:0] r_t3_idx;
    logic [60:0]      w_d;
    logic [46:0]      w_num;
    logic [46:0]      w_lres;

    assign w_d    = {r_t2_ph, 23'b0} + 61'(r_t2_pl) + (61'(r_bright) << FRAC_BITS);
    assign w_num  = {1'b0, r_t2_plin, 20'b0} + 47'(r_bright) * 47'(LIN_BRIGHT);
    assign w_lres = w_num >> LIN_SHIFT;

    // output stage: (d*65535)>>44, saturated
    logic [60:0] w_pw;
    logic [16:0] w_pres;
    logic [15:0] w_pv;

    assign w_pw   = {r_t3_d, 16'b0} - 61'(r_t3_d);
    assign w_pres = w_pw[60:44];
    assign w_pv   = (r_t3_sat || w_pres[16]) ? 16'hFFFF : w_pres[15:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t1_valid  <= 1'b0;
            r_t2_valid  <= 1'b0;
            r_t3_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (ce) begin
            r_t1_valid  <= w_exp_valid;
            r_t2_valid  <= r_t1_valid;
            r_t3_valid  <= r_t2_valid;
            r_out_valid <= r_t3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_t1_y       <= w_y48[44:0];
            r_t1_sat     <= w_exp_tag.sat || (w_y48[47:45] != '0);
            r_t1_idx     <= w_exp_tag.idx;
            r_t2_pl      <= r_t1_y[22:0] * r_contrast;
            r_t2_ph      <= r_t1_y[44:23] * r_contrast;
            r_t2_plin    <= w_sidx * r_contrast;
            r_t2_sat     <= r_t1_sat;
            r_t2_idx     <= r_t1_idx;
            r_t3_d       <= w_d[44:0];
            r_t3_sat     <= r_t2_sat || (w_d[60:45] != '0);
            r_t3_lin     <= (w_lres > 47'd65535) ? 16'hFFFF : w_lres[15:0];
            r_t3_idx     <= r_t2_idx;
            o_ramp_value <= w_lin ? r_t3_lin : w_pv;
        end
    end

    `GRG_ASSERT_NEXT(a_sat_out, i_clk, i_rst_n, (ce && r_t3_valid && r_t3_sat && !w_lin), (o_ramp_value == 16'hFFFF))
    `GRG_ASSERT(a_exp_norm, i_clk, i_rst_n, (w_exp_valid |-> w_exp_r[30]))
    `GRG_ASSERT(a_zero_idx, i_clk, i_rst_n, ((r_t3_valid && r_t3_idx == '0 && !w_lin) |-> (r_t3_d == (45'(r_bright) << FRAC_BITS))))

endmodule
